@@ rtl/odo_pkg.sv @@
package odo_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int CordCntW    = $clog2(CordicSteps);

  localparam int DivBits   = 52;
  localparam int DivCycles = DivBits / 2;
  localparam int DivCntW   = $clog2(DivCycles);

  localparam logic [29:0] RadToBa   = 30'd683565276;
  localparam logic [33:0] CordGain  = 34'd652032874;
  localparam logic [17:0] HwsReset  = 18'd6554;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_NUM    = 9'b000000010,
    S_DSTART = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_CSTART = 9'b000010000,
    S_CORD   = 9'b000100000,
    S_MULX   = 9'b001000000,
    S_MULY   = 9'b010000000,
    S_UPD    = 9'b100000000
  } state_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:    a = 30'h20000000;
      5'd1:    a = 30'h12E4051E;
      5'd2:    a = 30'h09FB385B;
      5'd3:    a = 30'h051111D4;
      5'd4:    a = 30'h028B0D43;
      5'd5:    a = 30'h0145D7E1;
      5'd6:    a = 30'h00A2F61E;
      5'd7:    a = 30'h00517C55;
      5'd8:    a = 30'h0028BE53;
      5'd9:    a = 30'h00145F2F;
      5'd10:   a = 30'h000A2F98;
      5'd11:   a = 30'h000517CC;
      5'd12:   a = 30'h00028BE6;
      5'd13:   a = 30'h000145F3;
      5'd14:   a = 30'h0000A2FA;
      5'd15:   a = 30'h0000517D;
      5'd16:   a = 30'h000028BE;
      5'd17:   a = 30'h0000145F;
      5'd18:   a = 30'h00000A30;
      5'd19:   a = 30'h00000518;
      5'd20:   a = 30'h0000028C;
      5'd21:   a = 30'h00000146;
      5'd22:   a = 30'h000000A3;
      5'd23:   a = 30'h00000051;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

  // {quotient bit, new remainder}
  function automatic logic [19:0] div_step(input logic [18:0] rem, input logic nbit,
                                           input logic [18:0] den);
    logic [19:0] r;
    logic [19:0] d;
    r = {rem, nbit};
    d = {1'b0, den};
    if (r >= d) begin
      r = r - d;
      return {1'b1, r[18:0]};
    end
    return {1'b0, r[18:0]};
  endfunction

endpackage

@@ rtl/diff_drive_odometry.sv @@
// An input transfer steps through S_NUM, the turn divider, the CORDIC, S_MULX,
// S_MULY and S_UPD to out_valid; S_UPD waits while an earlier result is not taken.
// A new input is taken only in S_IDLE, once the 2-bit-per-cycle turn
// divider, the 16 CORDIC iterations and the update of the last one have finished.
// Reset (rst, synchronous): pose cleared to zero, half_wheel_spacing 6554.
module diff_drive_odometry (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [19:0] left_distance,
  input  logic signed [19:0] right_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  input  logic               cfg_we,
  input  logic [17:0]        cfg_data
);

  odo_pkg::state_t     state;
  odo_pkg::state_t     state_next;
  logic [17:0]         hws;
  logic [17:0]         hws_eff;
  logic signed [31:0]  pose_x;
  logic signed [31:0]  pose_y;
  logic [15:0]         pose_heading;
  logic signed [20:0]  diff;
  logic signed [20:0]  sum;
  logic [20:0]         mag;
  logic [50:0]         num;
  logic [51:0]         dividend;
  logic                div_done;
  logic [32:0]         quot;
  logic [32:0]         tq;
  logic [31:0]         phase;
  logic [31:0]         tq_rnd;
  logic                cord_done;
  logic signed [33:0]  cos_q30;
  logic signed [33:0]  sin_q30;
  logic signed [33:0]  mul_op;
  logic signed [54:0]  prod;
  logic signed [54:0]  prod_x;
  logic signed [54:0]  prod_y;
  logic signed [54:0]  rx;
  logic signed [54:0]  ry;
  logic signed [33:0]  nx;
  logic signed [33:0]  ny;
  logic signed [31:0]  sx;
  logic signed [31:0]  sy;
  logic                in_xfer;
  logic                out_free;

  assign in_ready = (state == odo_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign hws_eff  = (hws == '0) ? 18'd1 : hws;
  assign mag      = diff[20] ? 21'(-diff) : 21'(diff);
  assign dividend = {1'b0, num} + {34'd0, hws_eff};

  assign tq     = diff[20] ? 33'(-quot) : quot;
  assign phase  = {pose_heading, 16'h0000} + tq[32:1];
  assign tq_rnd = tq[31:0] + 32'h0000_8000;

  assign mul_op = (state == odo_pkg::S_MULY) ? sin_q30 : cos_q30;
  assign prod   = sum * mul_op;

  assign rx = prod_x + (55'sd1 <<< 30);
  assign ry = prod_y + (55'sd1 <<< 30);
  assign nx = {{2{pose_x[31]}}, pose_x} + {{10{rx[54]}}, rx[54:31]};
  assign ny = {{2{pose_y[31]}}, pose_y} + {{10{ry[54]}}, ry[54:31]};

  always_comb begin
    if (nx[33:31] == 3'b000 || nx[33:31] == 3'b111) sx = nx[31:0];
    else if (nx[33]) sx = 32'sh8000_0000;
    else sx = 32'sh7FFF_FFFF;
    if (ny[33:31] == 3'b000 || ny[33:31] == 3'b111) sy = ny[31:0];
    else if (ny[33]) sy = 32'sh8000_0000;
    else sy = 32'sh7FFF_FFFF;
  end

  odo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == odo_pkg::S_DSTART),
    .dividend (dividend),
    .divisor  ({hws_eff, 1'b0}),
    .done     (div_done),
    .quot     (quot)
  );

  odo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == odo_pkg::S_CSTART),
    .phase   (phase),
    .done    (cord_done),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  always_comb begin
    state_next = state;
    case (state)
      odo_pkg::S_IDLE:   if (in_xfer) state_next = odo_pkg::S_NUM;
      odo_pkg::S_NUM:    state_next = odo_pkg::S_DSTART;
      odo_pkg::S_DSTART: state_next = odo_pkg::S_DIV;
      odo_pkg::S_DIV:    if (div_done) state_next = odo_pkg::S_CSTART;
      odo_pkg::S_CSTART: state_next = odo_pkg::S_CORD;
      odo_pkg::S_CORD:   if (cord_done) state_next = odo_pkg::S_MULX;
      odo_pkg::S_MULX:   state_next = odo_pkg::S_MULY;
      odo_pkg::S_MULY:   state_next = odo_pkg::S_UPD;
      odo_pkg::S_UPD:    if (out_free) state_next = odo_pkg::S_IDLE;
      default:           state_next = odo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= odo_pkg::S_IDLE;
      hws          <= odo_pkg::HwsReset;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) hws <= cfg_data;
      if (state == odo_pkg::S_UPD && out_free) begin
        pose_x       <= sx;
        pose_y       <= sy;
        pose_heading <= pose_heading + tq_rnd[31:16];
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      diff <= 21'(right_distance) - 21'(left_distance);
      sum  <= 21'(right_distance) + 21'(left_distance);
    end
    if (state == odo_pkg::S_NUM) num <= mag * odo_pkg::RadToBa;
    if (state == odo_pkg::S_MULX) prod_x <= prod;
    if (state == odo_pkg::S_MULY) prod_y <= prod;
    if (state == odo_pkg::S_UPD && out_free) begin
      pos_x   <= sx;
      pos_y   <= sy;
      heading <= pose_heading + tq_rnd[31:16];
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == odo_pkg::S_DIV)
    else $error("divider finished outside its wait state");

  a_cord_done_in_cord: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> state == odo_pkg::S_CORD)
    else $error("CORDIC finished outside its wait state");

  a_xfer_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == odo_pkg::S_NUM)
    else $error("input transfer did not start the update");

  a_result_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == odo_pkg::S_UPD))
    else $error("result raised outside the pose update");
`endif

endmodule

@@ rtl/odo_div.sv @@
module odo_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [51:0] dividend,
  input  logic [18:0] divisor,
  output logic        done,
  output logic [32:0] quot
);

  logic                              busy;
  logic [odo_pkg::DivCntW-1:0]       cnt;
  logic [51:0]                       shreg;
  logic [18:0]                       rem;
  logic [18:0]                       den;
  logic [19:0]                       s1;
  logic [19:0]                       s2;

  assign s1 = odo_pkg::div_step(rem, shreg[51], den);
  assign s2 = odo_pkg::div_step(s1[18:0], shreg[50], den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == odo_pkg::DivCntW'(odo_pkg::DivCycles - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      den   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[49:0], 2'b00};
      rem   <= s2[18:0];
      quot  <= {quot[30:0], s1[19], s2[19]};
    end
  end

endmodule

@@ rtl/odo_cordic.sv @@
module odo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);

  logic                          busy;
  logic [odo_pkg::CordCntW-1:0]  idx;
  logic [1:0]                    quad;
  logic signed [33:0]            x;
  logic signed [33:0]            y;
  logic signed [32:0]            z;
  logic signed [33:0]            xs;
  logic signed [33:0]            ys;
  logic signed [32:0]            at;

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = $signed({3'b000, odo_pkg::atan_entry(5'(idx))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == odo_pkg::CordCntW'(odo_pkg::CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= $signed(odo_pkg::CordGain);
      y    <= '0;
      z    <= $signed({3'b000, phase[29:0]});
      quad <= phase[31:30];
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0: begin
        cos_q30 = x;
        sin_q30 = y;
      end
      2'd1: begin
        cos_q30 = -y;
        sin_q30 = x;
      end
      2'd2: begin
        cos_q30 = -x;
        sin_q30 = -y;
      end
      default: begin
        cos_q30 = y;
        sin_q30 = -x;
      end
    endcase
  end

endmodule

@@ tb/sv/diff_drive_odometry_tb.sv @@
module diff_drive_odometry_tb;

  localparam int Steps     = odo_pkg::CordicSteps;
  localparam int Latency   = 50;
  localparam int MaxCycles = 1500000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [19:0] left_distance;
  logic signed [19:0] right_distance;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic               cfg_we;
  logic [17:0]        cfg_data;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hd;
  } pose_t;

  pose_t       pose_q[$];
  logic [17:0] hws_cfg;
  pose_t       pose_now;
  int          n_fail;
  int          n_items;
  int          n_poses;
  int          cycles;
  bit          idle_on;
  bit          sat_seen;

  diff_drive_odometry dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .left_distance(left_distance), .right_distance(right_distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a, longint d);
    longint r;
    r = longint'(a) + d;
    if (r > 64'sd2147483647) return 32'h7fffffff;
    if (r < -64'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  function automatic longint atan_turn(int i);
    logic [31:0] t [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return longint'(t[i]);
  endfunction

  function automatic void advance_pose(logic signed [19:0] l, logic signed [19:0] r);
    longint sl, sr, diff, sum, hws, den, num, mag, q, tq, z, x, y, xs, ys;
    longint c, s, dx, dy;
    logic [31:0] phase;
    logic [63:0] tqb;
    logic [15:0] dh;
    sl = l;
    sr = r;
    diff = sr - sl;
    sum = sr + sl;
    hws = (hws_cfg == 0) ? 1 : longint'(hws_cfg);
    den = 2 * hws;
    num = diff * 64'sd683565276;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    tq = num < 0 ? -q : q;
    tqb = tq;
    phase = {pose_now.hd, 16'h0} + tqb[32:1];
    z = longint'({2'b00, phase[29:0]});
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_turn(i);
      end else begin
        x += ys; y -= xs; z += atan_turn(i);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    dx = floor_shr(sum * c + (64'sd1 <<< 30), 31);
    dy = floor_shr(sum * s + (64'sd1 <<< 30), 31);
    pose_now.x = sat_add(pose_now.x, dx);
    pose_now.y = sat_add(pose_now.y, dy);
    if (pose_now.x == 32'h7fffffff || pose_now.x == 32'h80000000) sat_seen = 1;
    tqb = tq + 32768;
    dh = tqb[31:16];
    pose_now.hd = pose_now.hd + dh;
    pose_q.push_back(pose_now);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // check each result transfer
  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d heading=%0d", pos_x, pos_y, heading);
        n_fail++;
      end else begin
        e = pose_q.pop_front();
        n_poses++;
        if (pos_x !== e.x) begin
          $error("pos_x expected %0d actual %0d", e.x, pos_x);
          n_fail++;
        end
        if (pos_y !== e.y) begin
          $error("pos_y expected %0d actual %0d", e.y, pos_y);
          n_fail++;
        end
        if (heading !== e.hd) begin
          $error("heading expected %0d actual %0d", e.hd, heading);
          n_fail++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int k;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_distances(logic signed [19:0] l, logic signed [19:0] r);
    int k;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_distance <= l;
    right_distance <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_pose(l, r);
    n_items++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pose_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_spacing(logic [17:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hws_cfg = v;
  endtask

  task automatic test_extremes();
    logic signed [19:0] ext [4] = '{20'sh80000, 20'sh7ffff, 20'sh0, 20'shfffff};
    send_distances(20'sd0, 20'sd0);
    foreach (ext[i]) foreach (ext[j]) send_distances(ext[i], ext[j]);
    send_distances(20'sd65536, 20'sd65536);
    send_distances(20'sh55555, 20'shaaaaa);
    send_distances(20'shaaaaa, 20'sh55555);
  endtask

  task automatic test_spacing_extremes();
    logic [17:0] vals [5] = '{18'd0, 18'd1, 18'd131072, 18'h3ffff, 18'd6554};
    foreach (vals[i]) begin
      write_spacing(vals[i]);
      send_distances(20'sd1, 20'sd2);
      send_distances(20'sh80000, 20'sh7ffff);
      send_distances(20'($urandom), 20'($urandom));
    end
  endtask

  task automatic test_saturation();
    write_spacing(18'd131072);
    // drive straight at full speed
    repeat (150) begin
      send_distances(20'sh7ffff, 20'sh7ffff);
      if (sat_seen) break;
    end
    repeat (8) send_distances(20'sh7ffff, 20'sh7ffff);
    repeat (8) send_distances(20'sh80000, 20'sh80000);
  endtask

  task automatic test_random(int n);
    logic signed [19:0] l, r;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 299) write_spacing(18'($urandom_range(1, 131072)));
      case ($urandom_range(0, 3))
        0: begin l = 20'($urandom); r = 20'($urandom); end
        1: begin
          l = 20'($urandom_range(0, 4000));
          r = l + 20'($urandom_range(0, 200)) - 20'sd100;
        end
        2: begin l = -20'($urandom_range(0, 4000)); r = 20'($urandom_range(0, 4000)); end
        default: begin l = 20'($urandom); r = -l; end
      endcase
      send_distances(l, r);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    left_distance = '0;
    right_distance = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hws_cfg = odo_pkg::HwsReset;
    pose_now = '0;
    n_items = 0;
    idle_on = 1'b1;
    sat_seen = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_spacing_extremes();
    test_random(900);
    drain();
    test_saturation();
    idle_on = 1'b0;
    test_random(250);
    drain();
    $display("covered %0d transfers in, %0d poses checked, spacing from 0 to max,",
             n_items, n_poses);
    $display("position saturation %s", sat_seen ? "reached" : "not reached");
    if (n_fail == 0 && pose_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
